// ===== rtl/tlf_pkg.sv =====
package tlf_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned FrameW = 8;
    localparam int unsigned CodeW  = 3;
    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned CfgDataW = 32;

    localparam logic [TimeW-1:0]  LostTimeoutReset   = 32'd200000;
    localparam logic [FrameW-1:0] ConfirmFramesReset = 8'd10;
    localparam logic [FrameW-1:0] FrameMax           = 8'd255;

    localparam logic [CfgIdxW-1:0] CFG_LOST_TIMEOUT   = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_CONFIRM_FRAMES = 1'b1;

    typedef enum logic [1:0] {
        OP_MAIN_DETECT   = 2'd0,
        OP_MAIN_LOST     = 2'd1,
        OP_SENSOR_DETECT = 2'd2,
        OP_SENSOR_LOST   = 2'd3
    } op_t;

    typedef enum logic [6:0] {
        ST_SENSE_LOST   = 7'b0000001,
        ST_SENSE_DETECT = 7'b0000010,
        ST_MAIN_LOST    = 7'b0000100,
        ST_FITTING      = 7'b0001000,
        ST_TRACKING     = 7'b0010000,
        ST_TEMP_LOST    = 7'b0100000,
        ST_LOST         = 7'b1000000
    } state_t;

    localparam logic [CodeW-1:0] CODE_SENSE_LOST   = 3'd0;
    localparam logic [CodeW-1:0] CODE_SENSE_DETECT = 3'd1;
    localparam logic [CodeW-1:0] CODE_MAIN_LOST    = 3'd2;
    localparam logic [CodeW-1:0] CODE_FITTING      = 3'd3;
    localparam logic [CodeW-1:0] CODE_TRACKING     = 3'd4;
    localparam logic [CodeW-1:0] CODE_TEMP_LOST    = 3'd5;
    localparam logic [CodeW-1:0] CODE_LOST         = 3'd6;

    typedef struct packed {
        logic [1:0]       op;
        logic [TimeW-1:0] now_us;
    } in_t;

    typedef struct packed {
        logic [CodeW-1:0] life_state;
        logic             fit_restart;
        logic             is_tracking;
    } out_t;

    function automatic logic [CodeW-1:0] state_code(input state_t st);
        logic [CodeW-1:0] code;
        case (st)
            ST_SENSE_LOST:   code = CODE_SENSE_LOST;
            ST_SENSE_DETECT: code = CODE_SENSE_DETECT;
            ST_MAIN_LOST:    code = CODE_MAIN_LOST;
            ST_FITTING:      code = CODE_FITTING;
            ST_TRACKING:     code = CODE_TRACKING;
            ST_TEMP_LOST:    code = CODE_TEMP_LOST;
            ST_LOST:         code = CODE_LOST;
            default:         code = CODE_SENSE_LOST;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/target_track_lifecycle_fsm_core.sv =====
// latency: a result is shown the cycle after its item is accepted while the output is free
// throughput: one item per cycle while the skid entry is empty, set by the registered state update
// a skid entry behind the result register takes one more item when the output stalls,
// then input closes until the result register drains
// reset: synchronous active-low aresetn; state goes to sensing lost, frame count
// and last detect time to zero, registers to their defaults, output buffer empty
module target_track_lifecycle_fsm_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [tlf_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [tlf_pkg::CfgDataW-1:0]       cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  tlf_pkg::in_t                       s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output tlf_pkg::out_t                      m_data
);

    logic [tlf_pkg::TimeW-1:0]  lost_timeout_reg;
    logic [tlf_pkg::FrameW-1:0] confirm_frames_reg;

    tlf_pkg::state_t            state_reg, state_next;
    logic [tlf_pkg::FrameW-1:0] frame_count_reg, frame_count_next;
    logic [tlf_pkg::TimeW-1:0]  last_detect_reg, last_detect_next;

    logic                       m_valid_reg, m_valid_next;
    tlf_pkg::out_t              m_data_reg, m_data_next;
    logic                       skid_valid_reg, skid_valid_next;
    tlf_pkg::out_t              skid_data_reg, skid_data_next;

    logic                       push;
    logic                       pop;
    logic                       restart;
    logic [tlf_pkg::FrameW-1:0] count_inc;
    logic [tlf_pkg::TimeW-1:0]  elapsed;
    tlf_pkg::out_t              result;

    assign s_ready = !skid_valid_reg;
    assign push    = s_valid && s_ready;
    assign pop     = m_valid_reg && m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign count_inc = (frame_count_reg == tlf_pkg::FrameMax) ? frame_count_reg
                                                              : frame_count_reg + 8'd1;
    assign elapsed   = s_data.now_us - last_detect_reg;

    // next lifecycle state for the incoming item
    always_comb begin
        state_next       = state_reg;
        frame_count_next = frame_count_reg;
        last_detect_next = last_detect_reg;
        restart          = 1'b0;
        case (tlf_pkg::op_t'(s_data.op))
            tlf_pkg::OP_MAIN_DETECT: begin
                last_detect_next = s_data.now_us;
                frame_count_next = count_inc;
                if (state_reg == tlf_pkg::ST_SENSE_LOST ||
                    state_reg == tlf_pkg::ST_SENSE_DETECT ||
                    state_reg == tlf_pkg::ST_MAIN_LOST) begin
                    state_next = tlf_pkg::ST_FITTING;
                    restart    = 1'b1;
                end else if (state_reg == tlf_pkg::ST_TEMP_LOST) begin
                    state_next = tlf_pkg::ST_TRACKING;
                end else if (state_reg == tlf_pkg::ST_FITTING &&
                             count_inc >= confirm_frames_reg) begin
                    state_next = tlf_pkg::ST_TRACKING;
                end
            end
            tlf_pkg::OP_MAIN_LOST: begin
                frame_count_next = '0;
                if (state_reg == tlf_pkg::ST_FITTING ||
                    state_reg == tlf_pkg::ST_TRACKING) begin
                    state_next = tlf_pkg::ST_TEMP_LOST;
                end else if (state_reg == tlf_pkg::ST_TEMP_LOST &&
                             elapsed > lost_timeout_reg) begin
                    state_next = tlf_pkg::ST_LOST;
                end
            end
            tlf_pkg::OP_SENSOR_DETECT: begin
                if (state_reg == tlf_pkg::ST_SENSE_LOST ||
                    state_reg == tlf_pkg::ST_LOST) begin
                    state_next = tlf_pkg::ST_SENSE_DETECT;
                end
            end
            tlf_pkg::OP_SENSOR_LOST: begin
                if (state_reg == tlf_pkg::ST_SENSE_DETECT ||
                    state_reg == tlf_pkg::ST_LOST) begin
                    state_next = tlf_pkg::ST_SENSE_LOST;
                end
            end
            default: begin
                state_next = state_reg;
            end
        endcase
        result.life_state  = tlf_pkg::state_code(state_next);
        result.fit_restart = restart;
        result.is_tracking = (state_next == tlf_pkg::ST_TRACKING);
    end

    // output buffer: result register with a skid entry behind it
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!m_valid_reg || pop) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = push;
                m_data_next  = result;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lost_timeout_reg   <= tlf_pkg::LostTimeoutReset;
            confirm_frames_reg <= tlf_pkg::ConfirmFramesReset;
            state_reg          <= tlf_pkg::ST_SENSE_LOST;
            frame_count_reg    <= '0;
            last_detect_reg    <= '0;
            m_valid_reg        <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    tlf_pkg::CFG_LOST_TIMEOUT: begin
                        lost_timeout_reg <= cfg_wdata;
                    end
                    tlf_pkg::CFG_CONFIRM_FRAMES: begin
                        confirm_frames_reg <= cfg_wdata[tlf_pkg::FrameW-1:0];
                    end
                    default: begin
                        lost_timeout_reg <= lost_timeout_reg;
                    end
                endcase
            end
            if (push) begin
                state_reg       <= state_next;
                frame_count_reg <= frame_count_next;
                last_detect_reg <= last_detect_next;
            end
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== rtl/tlf_checker.sv =====
module tlf_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input tlf_pkg::out_t m_data
);

    // tracking flag agrees with the reported state
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.is_tracking == (m_data.life_state == tlf_pkg::CODE_TRACKING)))
        else $error("is_tracking disagrees with life_state");

    // a restart always lands in fitting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.fit_restart) |-> (m_data.life_state == tlf_pkg::CODE_FITTING))
        else $error("fit_restart without fitting state");

    // after an accepted item a result is valid on the next cycle, though it may be an older one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted item produced no result");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

bind target_track_lifecycle_fsm_core tlf_checker u_tlf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/tb_target_track_lifecycle_fsm_core.sv =====
module tb_target_track_lifecycle_fsm_core;

    import tlf_pkg::*;

    class track_scoreboard;
        logic [TimeW-1:0]  lost_timeout;
        logic [FrameW-1:0] confirm_frames;
        logic [CodeW-1:0]  life_code;
        logic [FrameW-1:0] frames;
        logic [TimeW-1:0]  last_seen_us;
        out_t              expected_q[$];
        int                errors;
        int                noted;
        int                checked;

        function new();
            lost_timeout   = LostTimeoutReset;
            confirm_frames = ConfirmFramesReset;
            life_code      = CODE_SENSE_LOST;
            frames         = '0;
            last_seen_us   = '0;
            errors         = 0;
            noted          = 0;
            checked        = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // next lifecycle state for one accepted item
        function void note_event(in_t item);
            out_t             res;
            logic [TimeW-1:0] elapsed;
            res = '0;
            case (op_t'(item.op))
                OP_MAIN_DETECT: begin
                    last_seen_us = item.now_us;
                    if (frames != FrameMax) begin
                        frames = frames + 8'd1;
                    end
                    case (life_code)
                        CODE_SENSE_LOST, CODE_SENSE_DETECT, CODE_MAIN_LOST: begin
                            life_code = CODE_FITTING;
                            res.fit_restart = 1'b1;
                        end
                        CODE_TEMP_LOST: begin
                            life_code = CODE_TRACKING;
                        end
                        CODE_FITTING: begin
                            if (frames >= confirm_frames) begin
                                life_code = CODE_TRACKING;
                            end
                        end
                        default: ;
                    endcase
                end
                OP_MAIN_LOST: begin
                    frames = '0;
                    if (life_code == CODE_FITTING || life_code == CODE_TRACKING) begin
                        life_code = CODE_TEMP_LOST;
                    end else if (life_code == CODE_TEMP_LOST) begin
                        elapsed = item.now_us - last_seen_us;
                        if (elapsed > lost_timeout) begin
                            life_code = CODE_LOST;
                        end
                    end
                end
                OP_SENSOR_DETECT: begin
                    if (life_code == CODE_SENSE_LOST || life_code == CODE_LOST) begin
                        life_code = CODE_SENSE_DETECT;
                    end
                end
                default: begin
                    if (life_code == CODE_SENSE_DETECT || life_code == CODE_LOST) begin
                        life_code = CODE_SENSE_LOST;
                    end
                end
            endcase
            res.life_state  = life_code;
            res.is_tracking = (life_code == CODE_TRACKING);
            expected_q.push_back(res);
            noted++;
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (expected_q.size() == 0) begin
                $error("result with no item outstanding: life_state %0d", got.life_state);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.life_state !== want.life_state) begin
                $error("life_state mismatch: expected %0d, actual %0d",
                       want.life_state, got.life_state);
                errors++;
            end
            if (got.fit_restart !== want.fit_restart) begin
                $error("fit_restart mismatch: expected %0d, actual %0d",
                       want.fit_restart, got.fit_restart);
                errors++;
            end
            if (got.is_tracking !== want.is_tracking) begin
                $error("is_tracking mismatch: expected %0d, actual %0d",
                       want.is_tracking, got.is_tracking);
                errors++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    in_t                 s_data;
    logic                m_valid;
    logic                m_ready;
    out_t                m_data;

    track_scoreboard     sb;
    int                  send_idle;
    int                  recv_idle;
    int                  settings_used;
    logic [TimeW-1:0]    clock_us;
    logic [TimeW-1:0]    last_detect_us;

    target_track_lifecycle_fsm_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("target_track_lifecycle_fsm_core verification failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
        end
    end

    task automatic send_event(input op_t op, input logic [TimeW-1:0] stamp);
        in_t item;
        item.op     = op;
        item.now_us = stamp;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        sb.note_event(item);
        if (op == OP_MAIN_DETECT) begin
            last_detect_us = stamp;
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (2) @(posedge aclk);
    endtask

    // upper bits of the frame-count word are junk the block must ignore
    task automatic apply_setting(input logic [TimeW-1:0] timeout, input logic [FrameW-1:0] frames);
        logic [CfgDataW-1:0] word;
        word        = $urandom();
        word[7:0]   = frames;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LOST_TIMEOUT;
        cfg_wdata <= timeout;
        @(posedge aclk);
        cfg_index <= CFG_CONFIRM_FRAMES;
        cfg_wdata <= word;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.lost_timeout   = timeout;
        sb.confirm_frames = frames;
        settings_used++;
    endtask

    // time of a further loss after the last detection, at, around or well away from the coast limit
    function automatic logic [TimeW-1:0] coast_stamp();
        logic [TimeW-1:0] delta;
        case ($urandom_range(4))
            0: delta = sb.lost_timeout - 1'b1;
            1: delta = sb.lost_timeout;
            2: delta = sb.lost_timeout + 1'b1;
            3: delta = $urandom_range(0, 1000);
            default: delta = $urandom();
        endcase
        return last_detect_us + delta;
    endfunction

    task automatic run_random(input int target);
        int done_n;
        int kind;
        int k;
        done_n = 0;
        while (done_n < target) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                k = $urandom_range(1, int'(sb.confirm_frames) + 3);
                repeat (k) begin
                    clock_us = clock_us + $urandom_range(1, 20000);
                    send_event(OP_MAIN_DETECT, clock_us);
                    done_n++;
                end
            end else if (kind < 65) begin
                clock_us = clock_us + $urandom_range(1, 20000);
                send_event(OP_MAIN_LOST, clock_us);
                done_n++;
                k = $urandom_range(1, 3);
                repeat (k) begin
                    clock_us = coast_stamp();
                    send_event(OP_MAIN_LOST, clock_us);
                    done_n++;
                end
                if ($urandom_range(1)) begin
                    clock_us = clock_us + $urandom_range(1, 20000);
                    send_event(OP_MAIN_DETECT, clock_us);
                    done_n++;
                end
            end else if (kind < 85) begin
                k = $urandom_range(1, 4);
                repeat (k) begin
                    clock_us = clock_us + $urandom_range(1, 500);
                    send_event($urandom_range(1) ? OP_SENSOR_DETECT : OP_SENSOR_LOST, clock_us);
                    done_n++;
                end
            end else begin
                send_event(op_t'($urandom_range(3)), $urandom());
                done_n++;
            end
        end
    endtask

    initial begin
        int wait_n;
        sb             = new();
        send_idle      = 28;
        recv_idle      = 28;
        settings_used  = 0;
        clock_us       = $urandom();
        last_detect_us = '0;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed walk through the lifecycle transitions with a short confirm count
        apply_setting(LostTimeoutReset, 8'd2);
        send_event(OP_SENSOR_LOST, 32'd0);
        send_event(OP_MAIN_LOST, 32'd0);
        send_event(OP_SENSOR_DETECT, 32'd1);
        send_event(OP_SENSOR_DETECT, 32'd2);
        send_event(OP_MAIN_LOST, 32'd3);
        send_event(OP_SENSOR_LOST, 32'd4);
        send_event(OP_SENSOR_DETECT, 32'd5);
        send_event(OP_MAIN_DETECT, 32'hFFFF_FFF0);
        send_event(OP_SENSOR_DETECT, 32'hFFFF_FFF1);
        send_event(OP_SENSOR_LOST, 32'hFFFF_FFF2);
        send_event(OP_MAIN_DETECT, 32'hFFFF_FFF8);
        send_event(OP_MAIN_DETECT, 32'hFFFF_FFFF);
        send_event(OP_MAIN_LOST, 32'd16);
        // coast exactly at the limit across the wrap, then one past it
        send_event(OP_MAIN_LOST, 32'd199999);
        send_event(OP_MAIN_LOST, 32'd200000);
        send_event(OP_MAIN_DETECT, 32'd300000);
        send_event(OP_MAIN_LOST, 32'd300001);
        send_event(OP_SENSOR_DETECT, 32'd300002);
        send_event(OP_MAIN_DETECT, 32'd400000);
        send_event(OP_MAIN_LOST, 32'd400001);
        send_event(OP_SENSOR_DETECT, 32'd400001);
        send_event(OP_SENSOR_LOST, 32'd400001);
        send_event(OP_MAIN_DETECT, 32'd400002);
        send_event(OP_MAIN_LOST, 32'd400003);
        send_event(OP_MAIN_LOST, 32'd400001);
        send_event(OP_SENSOR_LOST, 32'hFFFF_FFFF);
        drain();

        apply_setting(32'd0, 8'd1);
        run_random(300);
        drain();

        // long detection run drives the frame count into saturation
        apply_setting(32'hFFFF_FFFF, 8'd255);
        send_event(OP_MAIN_LOST, clock_us);
        repeat (300) begin
            clock_us = clock_us + 1'b1;
            send_event(OP_MAIN_DETECT, clock_us);
        end
        run_random(250);
        drain();

        send_idle = 0;
        recv_idle = 0;
        apply_setting(LostTimeoutReset, ConfirmFramesReset);
        run_random(300);
        drain();

        send_idle = 28;
        recv_idle = 28;
        apply_setting($urandom(), 8'd0);
        run_random(250);
        drain();

        apply_setting($urandom_range(1, 5000), 8'($urandom_range(1, 20)));
        run_random(350);

        s_valid <= 1'b0;
        wait_n = 0;
        while (sb.pending() != 0 && wait_n < 1000) begin
            @(posedge aclk);
            wait_n++;
        end
        repeat (4) @(posedge aclk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end

        $display("covered %0d lifecycle events, %0d results checked, %0d register settings",
                 sb.noted, sb.checked, settings_used);
        if (sb.errors == 0) begin
            $display("target_track_lifecycle_fsm_core verification clean");
        end else begin
            $display("target_track_lifecycle_fsm_core verification failed");
        end
        $finish;
    end

endmodule
